// ===== rtl/pct_pkg.sv =====
// ----------------------------------------------------------------------------
// pct_pkg: shared types and constants for the polygon convexity test
// Coordinate and intermediate widths, sequencer/datapath codes and the
// control words that pass between the sequencer, the MAC unit and the top.
// ----------------------------------------------------------------------------
package pct_pkg;

  localparam int COORD_BITS = 16;
  localparam int DIFF_W     = COORD_BITS + 1;      // vertex difference
  localparam int NORM_W     = 2 * DIFF_W + 1;      // plane normal component
  localparam int EDGE_W     = NORM_W + DIFF_W + 1; // n x (A-B) component
  localparam int PROD_W     = EDGE_W + DIFF_W;     // widest single product
  localparam int ACC_W      = PROD_W + 2;          // sum of three products

  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] NORM_LAST_STEP = STEP_W'(5);
  localparam logic [STEP_W-1:0] TEST_LAST_STEP = STEP_W'(8);

  // Vertex count class: saturates at SEEN_MANY (three or more)
  localparam logic [1:0] SEEN_ZERO = 2'd0;
  localparam logic [1:0] SEEN_ONE  = 2'd1;
  localparam logic [1:0] SEEN_TWO  = 2'd2;
  localparam logic [1:0] SEEN_MANY = 2'd3;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]     diff_t;
  typedef logic signed [NORM_W-1:0]     norm_t;
  typedef logic signed [EDGE_W-1:0]     edge_t;
  typedef logic signed [PROD_W-1:0]     prod_t;
  typedef logic signed [ACC_W-1:0]      acc_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } point_t;

  typedef struct packed {
    diff_t x;
    diff_t y;
    diff_t z;
  } diff_vec_t;

  typedef struct packed {
    norm_t x;
    norm_t y;
    norm_t z;
  } norm_vec_t;

  typedef struct packed {
    edge_t x;
    edge_t y;
    edge_t z;
  } edge_vec_t;

  // Work phase: plane normal, then the triple tests
  typedef enum logic [1:0] {
    PH_NORMAL = 2'd0,  // n = (V2-V1) x (V0-V1)
    PH_RUN    = 2'd1,  // (older, newer, current)
    PH_CLOSE  = 2'd2,  // (newer, current, first)
    PH_WRAP   = 2'd3   // (current, first, second)
  } phase_e;

  typedef enum logic [3:0] {
    A_UX, A_UY, A_UZ,
    A_NX, A_NY, A_NZ,
    A_EX, A_EY, A_EZ
  } a_sel_e;

  typedef enum logic [2:0] {
    B_UX, B_UY, B_UZ,
    B_DX, B_DY, B_DZ
  } b_sel_e;

  typedef enum logic [2:0] {
    DST_NONE, DST_NX, DST_NY, DST_NZ,
    DST_EX, DST_EY, DST_EZ, DST_SIGN
  } dst_e;

  typedef struct packed {
    logic en;     // a product is issued this cycle
    logic first;  // start a new sum instead of adding to it
    logic sub;    // subtract the product
    dst_e dst;    // where the updated sum goes
  } mac_ctl_t;

  typedef struct packed {
    a_sel_e   a_sel;
    b_sel_e   b_sel;
    mac_ctl_t ctl;
  } mul_op_t;

  typedef struct packed {
    logic    idle;
    logic    load;    // latch the difference vectors for phase
    phase_e  phase;
    logic    finish;  // commit the vertex and maybe the result
    mul_op_t op;
  } seq_t;

  function automatic diff_vec_t diff_f(point_t a, point_t b);
    diff_vec_t r;
    r.x = {a.x[COORD_BITS-1], a.x} - {b.x[COORD_BITS-1], b.x};
    r.y = {a.y[COORD_BITS-1], a.y} - {b.y[COORD_BITS-1], b.y};
    r.z = {a.z[COORD_BITS-1], a.z} - {b.z[COORD_BITS-1], b.z};
    return r;
  endfunction

endpackage

// ===== rtl/pct_mac.sv =====
// ----------------------------------------------------------------------------
// pct_mac: shared multiply-accumulate unit
// One signed multiplier with a registered product, followed by a wide
// accumulator that starts, adds or subtracts under the issued control word.
// ----------------------------------------------------------------------------
module pct_mac (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  pct_pkg::edge_t        a_i,
  input  pct_pkg::diff_t        b_i,
  input  pct_pkg::mac_ctl_t     ctl_i,
  output pct_pkg::acc_t         sum_o,
  output pct_pkg::mac_ctl_t     ctl_o
);

  pct_pkg::prod_t    a_ext;
  pct_pkg::prod_t    b_ext;
  pct_pkg::prod_t    prod_d;
  pct_pkg::prod_t    prod_q;
  pct_pkg::mac_ctl_t ctl_q;
  pct_pkg::acc_t     acc_q;
  pct_pkg::acc_t     base;
  pct_pkg::acc_t     addend;
  pct_pkg::acc_t     sum;

  assign a_ext  = {{(pct_pkg::PROD_W - pct_pkg::EDGE_W){a_i[pct_pkg::EDGE_W-1]}}, a_i};
  assign b_ext  = {{(pct_pkg::PROD_W - pct_pkg::DIFF_W){b_i[pct_pkg::DIFF_W-1]}}, b_i};
  assign prod_d = a_ext * b_ext;

  assign base   = ctl_q.first ? '0 : acc_q;
  assign addend = {{(pct_pkg::ACC_W - pct_pkg::PROD_W){prod_q[pct_pkg::PROD_W-1]}}, prod_q};
  assign sum    = ctl_q.sub ? base - addend : base + addend;

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '{en: 1'b0, first: 1'b0, sub: 1'b0, dst: pct_pkg::DST_NONE};
    end else begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_q.en) begin
      acc_q <= sum;
    end
  end

  assign sum_o = sum;
  assign ctl_o = ctl_q;

endmodule

// ===== rtl/pct_seq.sv =====
// ----------------------------------------------------------------------------
// pct_seq: sequencer for the convexity test
// Walks the phases of one vertex (normal, running triple, wraparound triples)
// and, in each phase, issues one multiplier op per cycle from a step table.
// ----------------------------------------------------------------------------
module pct_seq (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [1:0]    seen_i,
  input  logic          last_i,
  input  logic          out_block_i,
  output pct_pkg::seq_t seq_o
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_LOAD   = 5'b00010,
    S_RUN    = 5'b00100,
    S_DRAIN  = 5'b01000,
    S_FINISH = 5'b10000
  } state_e;

  state_e                         state_q, state_d;
  pct_pkg::phase_e                phase_q, phase_d;
  logic [pct_pkg::STEP_W-1:0]     step_q, step_d;
  logic                           last_q;
  logic                           wrap_q;
  logic [pct_pkg::STEP_W-1:0]     last_step;
  logic                           compute;
  pct_pkg::mul_op_t               op;

  // Normal: u x d. Triple: e = n x u, then e . d, sign into the flag.
  function automatic pct_pkg::mul_op_t op_f(logic norm, logic [pct_pkg::STEP_W-1:0] step);
    pct_pkg::mul_op_t r;
    r.a_sel     = pct_pkg::A_UX;
    r.b_sel     = pct_pkg::B_DX;
    r.ctl.en    = 1'b1;
    r.ctl.first = 1'b0;
    r.ctl.sub   = 1'b0;
    r.ctl.dst   = pct_pkg::DST_NONE;
    if (norm) begin
      case (step)
        4'd0: begin r.a_sel = pct_pkg::A_UY; r.b_sel = pct_pkg::B_DZ; r.ctl.first = 1'b1; end
        4'd1: begin
          r.a_sel = pct_pkg::A_UZ; r.b_sel = pct_pkg::B_DY;
          r.ctl.sub = 1'b1; r.ctl.dst = pct_pkg::DST_NX;
        end
        4'd2: begin r.a_sel = pct_pkg::A_UZ; r.b_sel = pct_pkg::B_DX; r.ctl.first = 1'b1; end
        4'd3: begin
          r.a_sel = pct_pkg::A_UX; r.b_sel = pct_pkg::B_DZ;
          r.ctl.sub = 1'b1; r.ctl.dst = pct_pkg::DST_NY;
        end
        4'd4: begin r.a_sel = pct_pkg::A_UX; r.b_sel = pct_pkg::B_DY; r.ctl.first = 1'b1; end
        default: begin
          r.a_sel = pct_pkg::A_UY; r.b_sel = pct_pkg::B_DX;
          r.ctl.sub = 1'b1; r.ctl.dst = pct_pkg::DST_NZ;
        end
      endcase
    end else begin
      case (step)
        4'd0: begin r.a_sel = pct_pkg::A_NY; r.b_sel = pct_pkg::B_UZ; r.ctl.first = 1'b1; end
        4'd1: begin
          r.a_sel = pct_pkg::A_NZ; r.b_sel = pct_pkg::B_UY;
          r.ctl.sub = 1'b1; r.ctl.dst = pct_pkg::DST_EX;
        end
        4'd2: begin r.a_sel = pct_pkg::A_NZ; r.b_sel = pct_pkg::B_UX; r.ctl.first = 1'b1; end
        4'd3: begin
          r.a_sel = pct_pkg::A_NX; r.b_sel = pct_pkg::B_UZ;
          r.ctl.sub = 1'b1; r.ctl.dst = pct_pkg::DST_EY;
        end
        4'd4: begin r.a_sel = pct_pkg::A_NX; r.b_sel = pct_pkg::B_UY; r.ctl.first = 1'b1; end
        4'd5: begin
          r.a_sel = pct_pkg::A_NY; r.b_sel = pct_pkg::B_UX;
          r.ctl.sub = 1'b1; r.ctl.dst = pct_pkg::DST_EZ;
        end
        4'd6: begin r.a_sel = pct_pkg::A_EX; r.b_sel = pct_pkg::B_DX; r.ctl.first = 1'b1; end
        4'd7: begin r.a_sel = pct_pkg::A_EY; r.b_sel = pct_pkg::B_DY; end
        default: begin
          r.a_sel = pct_pkg::A_EZ; r.b_sel = pct_pkg::B_DZ; r.ctl.dst = pct_pkg::DST_SIGN;
        end
      endcase
    end
    return r;
  endfunction

  assign compute   = (seen_i == pct_pkg::SEEN_TWO) || (seen_i == pct_pkg::SEEN_MANY);
  assign last_step = (phase_q == pct_pkg::PH_NORMAL) ? pct_pkg::NORM_LAST_STEP
                                                     : pct_pkg::TEST_LAST_STEP;

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    step_d  = step_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          if (compute) begin
            phase_d = (seen_i == pct_pkg::SEEN_TWO) ? pct_pkg::PH_NORMAL : pct_pkg::PH_RUN;
            state_d = S_LOAD;
          end else begin
            state_d = S_FINISH;
          end
        end
      end
      S_LOAD: begin
        step_d  = '0;
        state_d = S_RUN;
      end
      S_RUN: begin
        if (step_q == last_step) begin
          state_d = S_LOAD;
          unique case (phase_q)
            pct_pkg::PH_NORMAL: phase_d = pct_pkg::PH_RUN;
            pct_pkg::PH_RUN: begin
              if (wrap_q) begin
                phase_d = pct_pkg::PH_CLOSE;
              end else begin
                state_d = S_DRAIN;
              end
            end
            pct_pkg::PH_CLOSE: phase_d = pct_pkg::PH_WRAP;
            pct_pkg::PH_WRAP:  state_d = S_DRAIN;
            default:           state_d = S_DRAIN;
          endcase
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      // let the last product reach the accumulator
      S_DRAIN: state_d = S_FINISH;
      S_FINISH: begin
        if (!(last_q && out_block_i)) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      phase_q <= pct_pkg::PH_NORMAL;
      step_q  <= '0;
      last_q  <= 1'b0;
      wrap_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      step_q  <= step_d;
      if (start_i && (state_q == S_IDLE)) begin
        last_q <= last_i;
        wrap_q <= last_i && (seen_i == pct_pkg::SEEN_MANY);
      end
    end
  end

  always_comb begin
    op        = op_f(phase_q == pct_pkg::PH_NORMAL, step_q);
    op.ctl.en = (state_q == S_RUN);
  end

  assign seq_o.idle   = (state_q == S_IDLE);
  assign seq_o.load   = (state_q == S_LOAD);
  assign seq_o.phase  = phase_q;
  assign seq_o.finish = (state_q == S_FINISH) && !(last_q && out_block_i);
  assign seq_o.op     = op;

endmodule

// ===== rtl/polygon_convexity_test.sv =====
// ----------------------------------------------------------------------------
// polygon_convexity_test: convexity check of a planar 3-D polygon
// Takes vertices in ring order and reports on the vertex marked last.
// ----------------------------------------------------------------------------
// Vertices enter one word at a time; the block works on one vertex at a time
// and holds in_stall_o high until it is done. All products run through one
// shared 53x17 signed multiplier with a registered output and one wide
// accumulator, one product per cycle while a block of products runs: six for
// the plane normal and nine for each triple test, each block preceded by a
// load state that forms the vertex differences. Vertices 0 and 1 are only
// stored; vertex 2 runs the normal plus the first triple, each further vertex
// one triple, and a final vertex with four or more vertices in the polygon
// three triple tests. A result word is produced only on the last vertex and
// waits in an output register; the block stalls at the end of a last vertex
// only while the previous result is still held there.
// ----------------------------------------------------------------------------
module polygon_convexity_test (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  pct_pkg::coord_t        vertex_x_i,
  input  pct_pkg::coord_t        vertex_y_i,
  input  pct_pkg::coord_t        vertex_z_i,
  input  logic                   last_vertex_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic                   is_convex_result_o,
  output logic                   too_few_vertices_o
);

  logic                 accept;
  pct_pkg::seq_t        seq;
  pct_pkg::point_t      in_point;
  pct_pkg::point_t      cur_q, first_q, second_q, older_q, newer_q;
  pct_pkg::point_t      pa, pb, pc;
  logic                 last_q;
  logic [1:0]           seen_q;
  pct_pkg::diff_vec_t   u_q, d_q;
  pct_pkg::norm_vec_t   n_q;
  pct_pkg::edge_vec_t   e_q;
  logic                 convex_q;
  logic                 out_valid_q, convex_out_q, few_out_q;
  pct_pkg::edge_t       mul_a;
  pct_pkg::diff_t       mul_b;
  pct_pkg::acc_t        mac_sum;
  pct_pkg::mac_ctl_t    mac_ctl;

  assign in_stall_o = !seq.idle;
  assign accept     = in_valid_i && !in_stall_o;
  assign in_point   = '{x: vertex_x_i, y: vertex_y_i, z: vertex_z_i};

  pct_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (accept),
    .seen_i      (seen_q),
    .last_i      (last_vertex_i),
    .out_block_i (out_valid_q && out_stall_i),
    .seq_o       (seq)
  );

  // Points (a, b, c) of the current phase: u = a - b, d = c - b
  always_comb begin
    unique case (seq.phase)
      pct_pkg::PH_NORMAL: begin pa = cur_q;   pb = second_q; pc = first_q;  end
      pct_pkg::PH_RUN:    begin pa = older_q; pb = newer_q;  pc = cur_q;    end
      pct_pkg::PH_CLOSE:  begin pa = newer_q; pb = cur_q;    pc = first_q;  end
      pct_pkg::PH_WRAP:   begin pa = cur_q;   pb = first_q;  pc = second_q; end
      default:            begin pa = cur_q;   pb = first_q;  pc = second_q; end
    endcase
  end

  always_comb begin
    case (seq.op.a_sel)
      pct_pkg::A_UX: mul_a = {{(pct_pkg::EDGE_W - pct_pkg::DIFF_W){u_q.x[pct_pkg::DIFF_W-1]}}, u_q.x};
      pct_pkg::A_UY: mul_a = {{(pct_pkg::EDGE_W - pct_pkg::DIFF_W){u_q.y[pct_pkg::DIFF_W-1]}}, u_q.y};
      pct_pkg::A_UZ: mul_a = {{(pct_pkg::EDGE_W - pct_pkg::DIFF_W){u_q.z[pct_pkg::DIFF_W-1]}}, u_q.z};
      pct_pkg::A_NX: mul_a = {{(pct_pkg::EDGE_W - pct_pkg::NORM_W){n_q.x[pct_pkg::NORM_W-1]}}, n_q.x};
      pct_pkg::A_NY: mul_a = {{(pct_pkg::EDGE_W - pct_pkg::NORM_W){n_q.y[pct_pkg::NORM_W-1]}}, n_q.y};
      pct_pkg::A_NZ: mul_a = {{(pct_pkg::EDGE_W - pct_pkg::NORM_W){n_q.z[pct_pkg::NORM_W-1]}}, n_q.z};
      pct_pkg::A_EX: mul_a = e_q.x;
      pct_pkg::A_EY: mul_a = e_q.y;
      pct_pkg::A_EZ: mul_a = e_q.z;
      default:       mul_a = e_q.z;
    endcase
  end

  always_comb begin
    case (seq.op.b_sel)
      pct_pkg::B_UX: mul_b = u_q.x;
      pct_pkg::B_UY: mul_b = u_q.y;
      pct_pkg::B_UZ: mul_b = u_q.z;
      pct_pkg::B_DX: mul_b = d_q.x;
      pct_pkg::B_DY: mul_b = d_q.y;
      pct_pkg::B_DZ: mul_b = d_q.z;
      default:       mul_b = d_q.z;
    endcase
  end

  pct_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .ctl_i  (seq.op.ctl),
    .sum_o  (mac_sum),
    .ctl_o  (mac_ctl)
  );

  // Datapath registers: no reset needed
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cur_q <= in_point;
    end
    if (seq.load) begin
      u_q <= pct_pkg::diff_f(pa, pb);
      d_q <= pct_pkg::diff_f(pc, pb);
    end
    if (mac_ctl.en) begin
      case (mac_ctl.dst)
        pct_pkg::DST_NX: n_q.x <= mac_sum[pct_pkg::NORM_W-1:0];
        pct_pkg::DST_NY: n_q.y <= mac_sum[pct_pkg::NORM_W-1:0];
        pct_pkg::DST_NZ: n_q.z <= mac_sum[pct_pkg::NORM_W-1:0];
        pct_pkg::DST_EX: e_q.x <= mac_sum[pct_pkg::EDGE_W-1:0];
        pct_pkg::DST_EY: e_q.y <= mac_sum[pct_pkg::EDGE_W-1:0];
        pct_pkg::DST_EZ: e_q.z <= mac_sum[pct_pkg::EDGE_W-1:0];
        default: ;
      endcase
    end
    if (seq.finish) begin
      older_q <= newer_q;
      newer_q <= cur_q;
      if (seen_q == pct_pkg::SEEN_ZERO) begin
        first_q <= cur_q;
      end
      if (seen_q == pct_pkg::SEEN_ONE) begin
        second_q <= cur_q;
      end
    end
    if (seq.finish && last_q) begin
      convex_out_q <= (seen_q == pct_pkg::SEEN_TWO) ||
                      ((seen_q == pct_pkg::SEEN_MANY) && convex_q);
      few_out_q    <= (seen_q == pct_pkg::SEEN_ZERO) || (seen_q == pct_pkg::SEEN_ONE);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q      <= 1'b0;
      seen_q      <= pct_pkg::SEEN_ZERO;
      convex_q    <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        last_q <= last_vertex_i;
      end
      // a non-negative triple product fails the test
      if (mac_ctl.en && (mac_ctl.dst == pct_pkg::DST_SIGN)) begin
        convex_q <= convex_q & mac_sum[pct_pkg::ACC_W-1];
      end
      if (seq.finish) begin
        if (last_q) begin
          seen_q   <= pct_pkg::SEEN_ZERO;
          convex_q <= 1'b1;
        end else if (seen_q != pct_pkg::SEEN_MANY) begin
          seen_q <= seen_q + 1'b1;
        end
      end
      if (seq.finish && last_q) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o        = out_valid_q;
  assign is_convex_result_o = convex_out_q;
  assign too_few_vertices_o = few_out_q;

  // A new result word appears only at the end of a last vertex
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(seq.finish && last_q))
    else $error("result word without a finished last vertex");

  // A result never reports both convex and too few vertices
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(is_convex_result_o && too_few_vertices_o))
    else $error("conflicting result flags");

  // Only one vertex in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> in_stall_o)
    else $error("vertex taken while another is in work");

  // The sign of a triple product is only taken while a vertex is in work
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mac_ctl.en && (mac_ctl.dst == pct_pkg::DST_SIGN)) |-> !seq.idle)
    else $error("triple sign written outside a vertex");

endmodule

// ===== dv/tb_polygon_convexity_test.sv =====
// ----------------------------------------------------------------------------
// tb_polygon_convexity_test: self-checking bench for the polygon convexity test
// Streams polygons one vertex word at a time through the valid/stall input.
// An exact 128-bit integer predictor forms the expected verdict for every
// polygon, and each result word is checked against it or a typed verdict.
// ----------------------------------------------------------------------------
module tb_polygon_convexity_test;

  localparam int CYCLE_LIMIT = 4_000_000;
  localparam int DRAIN_CYCLES = 60;
  localparam int LONG_HOLD = 1200;

  typedef logic signed [127:0] big_t;

  typedef struct packed {
    big_t x;
    big_t y;
    big_t z;
  } vec_t;

  typedef struct packed {
    logic convex;
    logic few;
  } verdict_t;

  typedef struct packed {
    pct_pkg::coord_t x;
    pct_pkg::coord_t y;
    pct_pkg::coord_t z;
    logic            last;
    logic            typed;
    logic            want_convex;
    logic            want_few;
  } row_t;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_valid = 1'b0;
  logic            in_stall;
  pct_pkg::coord_t vx = '0;
  pct_pkg::coord_t vy = '0;
  pct_pkg::coord_t vz = '0;
  logic            vlast = 1'b0;
  logic            out_valid;
  logic            out_stall = 1'b0;
  logic            res_convex;
  logic            res_few;

  verdict_t verdicts_due[$];
  int       mismatches = 0;
  int       items_sent = 0;
  int       cycle_count = 0;
  int       gap_odds = 2;
  bit       quiet_tail = 1'b0;
  bit       hold_req = 1'b0;

  // polygon under construction in the predictor
  vec_t        corner0, corner1, prev2, prev1, normal;
  logic [15:0] vertex_count;
  bit          convex_ok;

  // extremes, every special case; verdict typed where it is obvious
  row_t script [0:24] = '{
    '{16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b1, 1'b0, 1'b1},
    '{-16'sd32768, -16'sd32768, -16'sd32768, 1'b0, 1'b0, 1'b0, 1'b0},
    '{16'sd32767, 16'sd32767, 16'sd32767, 1'b1, 1'b1, 1'b0, 1'b1},
    '{-16'sd32768, -16'sd32768, -16'sd32768, 1'b0, 1'b0, 1'b0, 1'b0},
    '{16'sd32767, -16'sd32768, 16'sd32767, 1'b0, 1'b0, 1'b0, 1'b0},
    '{16'sd32767, 16'sd32767, -16'sd32768, 1'b1, 1'b1, 1'b1, 1'b0},
    '{16'sd5, 16'sd5, 16'sd5, 1'b0, 1'b0, 1'b0, 1'b0},
    '{16'sd5, 16'sd5, 16'sd5, 1'b0, 1'b0, 1'b0, 1'b0},
    '{16'sd5, 16'sd5, 16'sd5, 1'b1, 1'b1, 1'b1, 1'b0},
    '{16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{16'sd100, 16'sd0, 16'sd0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{16'sd100, 16'sd100, 16'sd0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{16'sd0, 16'sd100, 16'sd0, 1'b1, 1'b0, 1'b0, 1'b0},
    '{16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{16'sd100, 16'sd0, 16'sd0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{16'sd20, 16'sd20, 16'sd0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{16'sd0, 16'sd100, 16'sd0, 1'b1, 1'b0, 1'b0, 1'b0},
    '{16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{16'sd1, 16'sd1, 16'sd1, 1'b0, 1'b0, 1'b0, 1'b0},
    '{16'sd2, 16'sd2, 16'sd2, 1'b0, 1'b0, 1'b0, 1'b0},
    '{16'sd3, 16'sd0, 16'sd7, 1'b1, 1'b0, 1'b0, 1'b0},
    '{-16'sd32768, 16'sd0, 16'sd32767, 1'b0, 1'b0, 1'b0, 1'b0},
    '{16'sd32767, -16'sd32768, 16'sd0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{16'sd0, 16'sd32767, -16'sd32768, 1'b0, 1'b0, 1'b0, 1'b0},
    '{-16'sd32768, -16'sd32768, 16'sd32767, 1'b1, 1'b0, 1'b0, 1'b0}
  };

  polygon_convexity_test uut (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall),
    .vertex_x_i         (vx),
    .vertex_y_i         (vy),
    .vertex_z_i         (vz),
    .last_vertex_i      (vlast),
    .out_valid_o        (out_valid),
    .out_stall_i        (out_stall),
    .is_convex_result_o (res_convex),
    .too_few_vertices_o (res_few)
  );

  always #6 clk = ~clk;

  function automatic vec_t mk_point(pct_pkg::coord_t x, pct_pkg::coord_t y,
                                    pct_pkg::coord_t z);
    vec_t p;
    p.x = big_t'(x);
    p.y = big_t'(y);
    p.z = big_t'(z);
    return p;
  endfunction

  function automatic vec_t vsub(vec_t a, vec_t b);
    vec_t r;
    r.x = a.x - b.x;
    r.y = a.y - b.y;
    r.z = a.z - b.z;
    return r;
  endfunction

  function automatic vec_t vcross(vec_t u, vec_t v);
    vec_t r;
    r.x = u.y * v.z - u.z * v.y;
    r.y = u.z * v.x - u.x * v.z;
    r.z = u.x * v.y - u.y * v.x;
    return r;
  endfunction

  // (n x (a-b)) . (c-b) must be strictly negative
  function automatic bit turns_inward(vec_t a, vec_t b, vec_t c);
    vec_t e, d;
    big_t s;
    e = vcross(normal, vsub(a, b));
    d = vsub(c, b);
    s = e.x * d.x + e.y * d.y + e.z * d.z;
    return s < 0;
  endfunction

  task automatic clear_polygon();
    corner0 = '0;
    corner1 = '0;
    prev2 = '0;
    prev1 = '0;
    normal = '0;
    vertex_count = '0;
    convex_ok = 1'b1;
  endtask

  task automatic predict_vertex(input pct_pkg::coord_t x, input pct_pkg::coord_t y,
                                input pct_pkg::coord_t z, input bit last,
                                output bit has_res, output verdict_t v);
    vec_t        p;
    logic [15:0] seen;
    p = mk_point(x, y, z);
    seen = vertex_count;
    has_res = 1'b0;
    v = '0;
    if (seen == 0) begin
      corner0 = p;
    end else if (seen == 1) begin
      corner1 = p;
    end else begin
      if (seen == 2) begin
        normal = vcross(vsub(p, corner1), vsub(corner0, corner1));
      end
      if (!turns_inward(prev2, prev1, p)) convex_ok = 1'b0;
      // close the ring: the two wraparound triples
      if (last && seen >= 3) begin
        if (!turns_inward(prev1, p, corner0)) convex_ok = 1'b0;
        if (!turns_inward(p, corner0, corner1)) convex_ok = 1'b0;
      end
    end
    prev2 = prev1;
    prev1 = p;
    if (vertex_count != 16'hFFFF) vertex_count = vertex_count + 16'd1;
    if (last) begin
      has_res = 1'b1;
      if (seen < 2) begin
        v.convex = 1'b0;
        v.few = 1'b1;
      end else if (seen == 2) begin
        v.convex = 1'b1;
        v.few = 1'b0;
      end else begin
        v.convex = convex_ok;
        v.few = 1'b0;
      end
      clear_polygon();
    end
  endtask

  task automatic send_vertex(input pct_pkg::coord_t x, input pct_pkg::coord_t y,
                             input pct_pkg::coord_t z, input bit last,
                             input bit typed, input verdict_t typed_v);
    bit       has_res;
    verdict_t v;
    if (!quiet_tail && $urandom_range(0, 15) < gap_odds) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat ($urandom_range(0, 16)) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    vx <= x;
    vy <= y;
    vz <= z;
    vlast <= last;
    do @(posedge clk); while (in_stall !== 1'b0);
    predict_vertex(x, y, z, last, has_res, v);
    if (has_res) verdicts_due.push_back(typed ? typed_v : v);
    items_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk);
  endtask

  // vertices on an ellipse in a random plane, sometimes with one vertex pulled in
  task automatic send_plane_polygon();
    int  n, r, i, a, b, dent_at;
    int  o[3], u[3], v[3];
    real ang0, step, t;
    bit  dent;
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(3, 12) : $urandom_range(3, 6);
    r = $urandom_range(50, 1000);
    for (i = 0; i < 3; i++) begin
      o[i] = $urandom_range(0, 30000);
      o[i] -= 15000;
      u[i] = $urandom_range(0, 16);
      u[i] -= 8;
      v[i] = $urandom_range(0, 16);
      v[i] -= 8;
    end
    ang0 = $urandom_range(0, 359) * 3.14159265 / 180.0;
    step = 2.0 * 3.14159265 / n;
    if ($urandom_range(0, 1) == 1) step = -step;
    dent = (n >= 4) && ($urandom_range(0, 3) == 0);
    dent_at = $urandom_range(0, n - 1);
    for (i = 0; i < n; i++) begin
      t = ang0 + i * step;
      a = int'(r * $cos(t));
      b = int'(r * $sin(t));
      if (dent && i == dent_at) begin
        a = a / 4;
        b = b / 4;
      end
      send_vertex(pct_pkg::coord_t'(o[0] + a * u[0] + b * v[0]),
                  pct_pkg::coord_t'(o[1] + a * u[1] + b * v[1]),
                  pct_pkg::coord_t'(o[2] + a * u[2] + b * v[2]), i == n - 1, 1'b0, '0);
    end
  endtask

  task automatic send_noise_polygon(input int n);
    int i;
    for (i = 0; i < n; i++) begin
      send_vertex(pct_pkg::coord_t'($urandom), pct_pkg::coord_t'($urandom),
                  pct_pkg::coord_t'($urandom), i == n - 1, 1'b0, '0);
    end
  endtask

  // receiver: random stall bursts, one long hold on request, quiet at the end
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        out_stall <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 17)) @(negedge clk);
        out_stall <= 1'b0;
        repeat ($urandom_range(0, 40)) @(negedge clk);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    verdict_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (verdicts_due.size() == 0) begin
        $display("%0t: unexpected result word convex=%0b few=%0b", $time, res_convex, res_few);
        mismatches++;
      end else begin
        want = verdicts_due.pop_front();
        if (res_convex !== want.convex) begin
          $display("%0t: is_convex_result expected %0b actual %0b", $time, want.convex,
                   res_convex);
          mismatches++;
        end
        if (res_few !== want.few) begin
          $display("%0t: too_few_vertices expected %0b actual %0b", $time, want.few, res_few);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("polygon_convexity_test regression: fail");
      $finish;
    end
  end

  initial begin
    int       k, pick;
    bit       held, drained;
    verdict_t typed_v;
    held = 1'b0;
    drained = 1'b0;
    clear_polygon();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (k = 0; k < 25; k++) begin
      typed_v.convex = script[k].want_convex;
      typed_v.few = script[k].want_few;
      send_vertex(script[k].x, script[k].y, script[k].z, script[k].last, script[k].typed,
                  typed_v);
    end

    while (items_sent < 750) begin
      gap_odds = $urandom_range(0, 4);
      if (!held && items_sent >= 300) begin
        // hold the output for a long while and keep offering words
        held = 1'b1;
        hold_req = 1'b1;
        for (k = 0; k < 6; k++) send_plane_polygon();
      end else if (!drained && items_sent >= 500) begin
        drained = 1'b1;
        wait_drained();
      end
      if (items_sent >= 640) quiet_tail = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 65) send_plane_polygon();
      else if (pick < 80) send_noise_polygon($urandom_range(1, 2));
      else send_noise_polygon($urandom_range(3, 8));
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("polygon_convexity_test regression: pass");
    end else begin
      $display("polygon_convexity_test regression: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/pct_pkg.sv
rtl/pct_mac.sv
rtl/pct_seq.sv
rtl/polygon_convexity_test.sv
dv/tb_polygon_convexity_test.sv
